[hdl/qrpc_pkg.sv]
package qrpc_pkg;

  localparam int unsigned DATA_W        = 8;
  localparam int unsigned POS_W         = 16;
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam int unsigned OUT_TDATA_W   = 40;
  localparam int unsigned VERDICT_W     = 34;

  localparam logic [POS_W-1:0]  MAX_PACKET_BYTES = 16'hFFFF;
  localparam logic [DATA_W-1:0] HDR_FF_BYTE      = 8'hFF;
  localparam logic [DATA_W-1:0] HDR_TAG_BYTE     = 8'h49;
  localparam logic [DATA_W-1:0] NUL_BYTE         = 8'h00;
  localparam logic [2:0]        HDR_FF_COUNT     = 3'd4;
  localparam logic [2:0]        NUM_STRINGS      = 3'd4;
  localparam logic [1:0]        ID_BYTES         = 2'd2;

  localparam logic [DATA_W-1:0] MIN_PLAYERS_RST  = 8'd4;
  localparam logic [DATA_W-1:0] SCAN_START_RST   = 8'd28;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_PLAYERS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_START  = 8'd1;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_PROTO,
    PH_STRINGS,
    PH_ID,
    PH_PLAYER,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] min_players;
    logic [DATA_W-1:0] scan_start;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_players;
    logic [DATA_W-1:0] old_players;
    logic [POS_W-1:0]  player_offset;
    logic              patch_needed;
    logic              header_found;
  } verdict_t;

endpackage

[hdl/qrpc_parser.sv]
module qrpc_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  logic [qrpc_pkg::DATA_W-1:0]   data_byte,
  input  logic                          last_byte,
  input  qrpc_pkg::cfg_t                cfg,
  output qrpc_pkg::verdict_t            verdict
);

  logic [qrpc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [2:0]                  ff_run_r, ff_run_nxt;
  qrpc_pkg::phase_t            phase_r, phase_nxt;
  logic [2:0]                  nulls_r, nulls_nxt;
  logic [1:0]                  id_left_r, id_left_nxt;
  logic [qrpc_pkg::POS_W-1:0]  off_r, off_nxt;
  logic [qrpc_pkg::DATA_W-1:0] players_r, players_nxt;
  logic                        parse_en;
  logic [2:0]                  nulls_inc;
  logic [1:0]                  id_dec;
  logic                        seen;
  logic                        patch;

  always_comb begin
    parse_en    = (pos_r != qrpc_pkg::MAX_PACKET_BYTES);
    pos_nxt     = parse_en ? pos_r + 16'd1 : pos_r;
    ff_run_nxt  = ff_run_r;
    phase_nxt   = phase_r;
    nulls_nxt   = nulls_r;
    id_left_nxt = id_left_r;
    off_nxt     = off_r;
    players_nxt = players_r;
    nulls_inc   = nulls_r + 3'd1;
    id_dec      = (id_left_r != 2'd0) ? id_left_r - 2'd1 : 2'd0;
    if (parse_en) begin
      case (phase_r)
        qrpc_pkg::PH_SEARCH: begin
          if (pos_r < {8'd0, cfg.scan_start}) begin
            ff_run_nxt = 3'd0;
          end else if (data_byte == qrpc_pkg::HDR_FF_BYTE) begin
            if (ff_run_r < qrpc_pkg::HDR_FF_COUNT) begin
              ff_run_nxt = ff_run_r + 3'd1;
            end
          end else if (data_byte == qrpc_pkg::HDR_TAG_BYTE &&
                       ff_run_r >= qrpc_pkg::HDR_FF_COUNT) begin
            ff_run_nxt = 3'd0;
            phase_nxt  = qrpc_pkg::PH_PROTO;
          end else begin
            ff_run_nxt = 3'd0;
          end
        end
        qrpc_pkg::PH_PROTO: begin
          nulls_nxt = 3'd0;
          phase_nxt = qrpc_pkg::PH_STRINGS;
        end
        qrpc_pkg::PH_STRINGS: begin
          if (data_byte == qrpc_pkg::NUL_BYTE) begin
            nulls_nxt = nulls_inc;
            if (nulls_inc >= qrpc_pkg::NUM_STRINGS) begin
              id_left_nxt = qrpc_pkg::ID_BYTES;
              phase_nxt   = qrpc_pkg::PH_ID;
            end
          end
        end
        qrpc_pkg::PH_ID: begin
          id_left_nxt = id_dec;
          if (id_dec == 2'd0) begin
            phase_nxt = qrpc_pkg::PH_PLAYER;
          end
        end
        qrpc_pkg::PH_PLAYER: begin
          off_nxt     = pos_r;
          players_nxt = data_byte;
          phase_nxt   = qrpc_pkg::PH_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    seen                  = (phase_nxt == qrpc_pkg::PH_DONE);
    patch                 = seen && (players_nxt < cfg.min_players);
    verdict.header_found  = (phase_nxt != qrpc_pkg::PH_SEARCH);
    verdict.patch_needed  = patch;
    verdict.player_offset = seen ? off_nxt : '0;
    verdict.old_players   = seen ? players_nxt : '0;
    verdict.new_players   = patch ? cfg.min_players : verdict.old_players;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      ff_run_r  <= '0;
      phase_r   <= qrpc_pkg::PH_SEARCH;
      nulls_r   <= '0;
      id_left_r <= '0;
      off_r     <= '0;
      players_r <= '0;
    end else if (adv) begin
      if (last_byte) begin
        pos_r     <= '0;
        ff_run_r  <= '0;
        phase_r   <= qrpc_pkg::PH_SEARCH;
        nulls_r   <= '0;
        id_left_r <= '0;
        off_r     <= '0;
        players_r <= '0;
      end else begin
        pos_r     <= pos_nxt;
        ff_run_r  <= ff_run_nxt;
        phase_r   <= phase_nxt;
        nulls_r   <= nulls_nxt;
        id_left_r <= id_left_nxt;
        off_r     <= off_nxt;
        players_r <= players_nxt;
      end
    end
  end

endmodule

[hdl/qrpc_out_reg.sv]
module qrpc_out_reg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  qrpc_pkg::verdict_t                verdict,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic [qrpc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              free
);

  logic               valid_r, valid_nxt;
  qrpc_pkg::verdict_t data_r;

  assign free = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= verdict;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(qrpc_pkg::OUT_TDATA_W - qrpc_pkg::VERDICT_W){1'b0}}, data_r};

endmodule

[hdl/query_reply_player_count_patcher.sv]
// Query reply player count patcher.
// Payload bytes enter on in_tdata, one per transaction, with in_tlast on the
// final byte of a packet. For each packet one verdict leaves on out_tdata
// after that final byte: header seen, patch needed, player byte offset, old
// and new player count. Bytes that are not the last produce no transaction.
// The cfg channel writes min_players (index 0) and scan_start (index 1);
// other indexes are dropped. cfg_ready is always high; write only while idle.
// Throughput: one byte per cycle unless a final byte waits for the output
// register. An accepted byte is held in the input register, where the parse
// logic updates the per-packet state; the verdict is loaded into the output
// register as the final byte leaves the input register, raising out_tvalid.
// When the receiver stalls, the held verdict stays put and non-final bytes
// keep flowing; a final byte waits in the input register until the output
// register frees, and in_tready drops only then.
// Reset (rst_n low, synchronous) clears all packet state and restores
// min_players to 4 and scan_start to 28.
module query_reply_player_count_patcher (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [qrpc_pkg::DATA_W-1:0]           in_tdata,   // [7:0] data_byte
  input  logic                                  in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] header_found, [1] patch_needed, [17:2] player_offset,
  // [25:18] old_players, [33:26] new_players, [39:34] zero
  output logic [qrpc_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [qrpc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [qrpc_pkg::DATA_W-1:0]           cfg_data
);

  qrpc_pkg::cfg_t              cfg_r;
  logic                        s1_valid_r, s1_valid_nxt;
  logic [qrpc_pkg::DATA_W-1:0] s1_data_r;
  logic                        s1_last_r;
  logic                        s1_adv;
  logic                        out_free;
  logic                        out_load;
  qrpc_pkg::verdict_t          verdict;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_players <= qrpc_pkg::MIN_PLAYERS_RST;
      cfg_r.scan_start  <= qrpc_pkg::SCAN_START_RST;
    end else if (cfg_valid) begin
      if (cfg_index == qrpc_pkg::REG_MIN_PLAYERS) begin
        cfg_r.min_players <= cfg_data;
      end else if (cfg_index == qrpc_pkg::REG_SCAN_START) begin
        cfg_r.scan_start <= cfg_data;
      end
    end
  end

  assign s1_adv    = s1_valid_r && (!s1_last_r || out_free);
  assign out_load  = s1_adv && s1_last_r;
  assign in_tready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  qrpc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (s1_adv),
    .data_byte (s1_data_r),
    .last_byte (s1_last_r),
    .cfg       (cfg_r),
    .verdict   (verdict)
  );

  qrpc_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .verdict    (verdict),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .free       (out_free)
  );

  a_patch_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0])
    else $error("patch flagged without header");

  a_patch_raises_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[33:26] > out_tdata[25:18])
    else $error("patch does not raise player count");

  a_no_patch_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[33:26] == out_tdata[25:18])
    else $error("count changed without patch");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && s1_last_r && out_tvalid && !out_tready)
    else $error("input stalled without a blocked verdict");

endmodule
